// ===== hdl/pwci_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, field widths, register indexes and reset values for the PID block.
package pwci_pkg;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned MEAS_W     = 10;
  localparam int unsigned ERR_W      = 12;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned LIM_W      = 23;
  localparam int unsigned DRIVE_W    = 24;
  localparam int unsigned SAT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd5;

  // Register reset values
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST    = -32'sd42949673;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST    = -32'sd214748;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST    = -32'sd85899346;
  localparam logic [MEAS_W-1:0]        MEAS_MIN_RST  = 10'd20;
  localparam logic [MEAS_W-1:0]        MEAS_MAX_RST  = 10'd1000;
  localparam logic [LIM_W-1:0]         OUT_LIMIT_RST = 23'd1966080;

  // Saturation side codes
  localparam logic [SAT_W-1:0] SAT_NONE = 2'd0;
  localparam logic [SAT_W-1:0] SAT_LOW  = 2'd1;
  localparam logic [SAT_W-1:0] SAT_HIGH = 2'd2;

  typedef struct packed {
    logic [RAW_W-1:0]  measurement;
    logic [MEAS_W-1:0] setpoint;
  } in_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [SAT_W-1:0]          saturated;
  } out_t;

endpackage

// ===== hdl/pwci_front.sv =====
`timescale 1ns / 1ps
// Measurement clamp, error, saturating error sum and error change (first stage).
module pwci_front import pwci_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  in_t                         in_i,
  input  logic [MEAS_W-1:0]           meas_min_i,
  input  logic [MEAS_W-1:0]           meas_max_i,
  output logic signed [ERR_W-1:0]     err_o,
  output logic signed [ERR_W-1:0]     diff_o,
  output logic signed [SUM_WIDTH-1:0] sum_o
);

  logic [MEAS_W-1:0]           meas_c;
  logic signed [ERR_W-1:0]     err_c;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [ERR_W-1:0]     prev_err_q, prev_err_d;
  logic signed [ERR_W-1:0]     diff_q, diff_d;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;

  always_comb begin
    // upper clamp is tested last, so it wins on a crossed window
    meas_c = in_i.measurement[MEAS_W-1:0];
    if (in_i.measurement < RAW_W'(meas_min_i)) begin
      meas_c = meas_min_i;
    end
    if (in_i.measurement > RAW_W'(meas_max_i)) begin
      meas_c = meas_max_i;
    end
    err_c = $signed({2'b00, in_i.setpoint}) - $signed({2'b00, meas_c});

    sum_ext = $signed({sum_q[SUM_WIDTH-1], sum_q})
            + $signed({{(SUM_WIDTH+1-ERR_W){err_c[ERR_W-1]}}, err_c});
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_d = sum_ext[SUM_WIDTH] ? $signed({1'b1, {(SUM_WIDTH-1){1'b0}}})
                                 : $signed({1'b0, {(SUM_WIDTH-1){1'b1}}});
    end else begin
      sum_d = sum_ext[SUM_WIDTH-1:0];
    end

    diff_d     = err_c - prev_err_q;
    prev_err_d = err_c;
  end

  // Controller state doubles as the stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      sum_q      <= '0;
    end else if (en_i) begin
      prev_err_q <= prev_err_d;
      sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
    end
  end

  assign err_o  = prev_err_q;
  assign diff_o = diff_q;
  assign sum_o  = sum_q;

endmodule

// ===== hdl/pwci_mult.sv =====
`timescale 1ns / 1ps
// Gain products, with the error sum split in two halves (second stage).
module pwci_mult import pwci_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      en_i,
  input  logic signed [GAIN_W-1:0]                  gain_p_i,
  input  logic signed [GAIN_W-1:0]                  gain_i_i,
  input  logic signed [GAIN_W-1:0]                  gain_d_i,
  input  logic signed [ERR_W-1:0]                   err_i,
  input  logic signed [ERR_W-1:0]                   diff_i,
  input  logic signed [SUM_WIDTH-1:0]               sum_i,
  output logic signed [GAIN_W+ERR_W-1:0]            prod_p_o,
  output logic signed [GAIN_W+ERR_W-1:0]            prod_d_o,
  output logic signed [GAIN_W+SUM_WIDTH/2:0]        prod_il_o,
  output logic signed [GAIN_W+SUM_WIDTH-SUM_WIDTH/2-1:0] prod_ih_o
);

  localparam int unsigned LO_W = SUM_WIDTH / 2;
  localparam int unsigned HI_W = SUM_WIDTH - LO_W;

  logic signed [LO_W:0]   sum_lo;
  logic signed [HI_W-1:0] sum_hi;

  // low half is unsigned, high half carries the sign
  assign sum_lo = $signed({1'b0, sum_i[LO_W-1:0]});
  assign sum_hi = sum_i[SUM_WIDTH-1:LO_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_p_o  <= gain_p_i * err_i;
      prod_d_o  <= gain_d_i * diff_i;
      prod_il_o <= gain_i_i * sum_lo;
      prod_ih_o <= gain_i_i * sum_hi;
    end
  end

endmodule

// ===== hdl/pwci_post.sv =====
`timescale 1ns / 1ps
// Product sum with rounding, then scaling and drive saturation (third and fourth stages).
module pwci_post import pwci_pkg::*; #(
  parameter int unsigned SUM_WIDTH     = 32,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      en_sum_i,
  input  logic                                      en_out_i,
  input  logic signed [GAIN_W+ERR_W-1:0]            prod_p_i,
  input  logic signed [GAIN_W+ERR_W-1:0]            prod_d_i,
  input  logic signed [GAIN_W+SUM_WIDTH/2:0]        prod_il_i,
  input  logic signed [GAIN_W+SUM_WIDTH-SUM_WIDTH/2-1:0] prod_ih_i,
  input  logic [LIM_W-1:0]                          out_limit_i,
  output out_t                                      out_o
);

  localparam int unsigned LO_W   = SUM_WIDTH / 2;
  localparam int unsigned SHIFT  = GAIN_W - OUT_FRAC_BITS;
  localparam int unsigned TOT_W  = SUM_WIDTH + GAIN_W + 2;
  localparam int unsigned FULL_W = TOT_W - SHIFT;
  localparam logic signed [TOT_W-1:0] ROUND =
    {{(TOT_W-SHIFT){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};

  logic signed [TOT_W-1:0]  total_d, total_q;
  logic signed [FULL_W-1:0] full_c, lim_pos, lim_neg;
  out_t                     out_d, out_q;

  // exact total plus half an output LSB
  assign total_d = (TOT_W'(prod_ih_i) <<< LO_W) + TOT_W'(prod_il_i)
                 + TOT_W'(prod_p_i) + TOT_W'(prod_d_i) + ROUND;

  always_ff @(posedge clk_i) begin
    if (en_sum_i) begin
      total_q <= total_d;
    end
  end

  always_comb begin
    full_c  = total_q[TOT_W-1:SHIFT];
    lim_pos = $signed({{(FULL_W-LIM_W){1'b0}}, out_limit_i});
    lim_neg = -lim_pos;
    priority if (full_c < lim_neg) begin
      out_d.drive     = lim_neg[DRIVE_W-1:0];
      out_d.saturated = SAT_LOW;
    end else if (full_c > lim_pos) begin
      out_d.drive     = lim_pos[DRIVE_W-1:0];
      out_d.saturated = SAT_HIGH;
    end else begin
      out_d.drive     = full_c[DRIVE_W-1:0];
      out_d.saturated = SAT_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ===== hdl/pid_with_clamped_input.sv =====
`timescale 1ns / 1ps
// Top level of the clamped-input PID controller with saturated drive.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (measurement, setpoint)
//   out      output     out_valid_o / out_stall_i out_data_o (drive, saturated)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Four register stages: clamp/error/sum update, gain products, product sum,
// scale and saturate into the output register. One transfer per cycle is
// sustained while the output is not stalled. Each stage advances when the
// stage after it is empty or advancing, so an output stall only backs up as
// far as needed and bubbles are squeezed out.
// Reset clears valid bits, the error sum and previous error, and loads the
// default gains, clamp window and drive limit.
module pid_with_clamped_input import pwci_pkg::*; #(
  parameter int unsigned SUM_WIDTH     = 32,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LO_W = SUM_WIDTH / 2;
  localparam int unsigned HI_W = SUM_WIDTH - LO_W;

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [MEAS_W-1:0]        meas_min_q, meas_max_q;
  logic [LIM_W-1:0]         out_limit_q;

  // Stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept, en2, en3, en4;

  // Stage payloads
  logic signed [ERR_W-1:0]          err_s1, diff_s1;
  logic signed [SUM_WIDTH-1:0]      sum_s1;
  logic signed [GAIN_W+ERR_W-1:0]   prod_p, prod_d;
  logic signed [GAIN_W+LO_W:0]      prod_il;
  logic signed [GAIN_W+HI_W-1:0]    prod_ih;

  // Write the addressed register; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= GAIN_P_RST;
      gain_i_q    <= GAIN_I_RST;
      gain_d_q    <= GAIN_D_RST;
      meas_min_q  <= MEAS_MIN_RST;
      meas_max_q  <= MEAS_MAX_RST;
      out_limit_q <= OUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_P:    gain_p_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_I:    gain_i_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_GAIN_D:    gain_d_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
        REG_MEAS_MIN:  meas_min_q  <= cfg_data_i[MEAS_W-1:0];
        REG_MEAS_MAX:  meas_max_q  <= cfg_data_i[MEAS_W-1:0];
        REG_OUT_LIMIT: out_limit_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its contents move on this cycle
  assign rdy4   = !v4_q || !out_stall_i;
  assign rdy3   = !v3_q || rdy4;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign accept = in_valid_i && rdy1;
  assign en2    = v1_q && rdy2;
  assign en3    = v2_q && rdy3;
  assign en4    = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  pwci_front #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .in_i       (in_data_i),
    .meas_min_i (meas_min_q),
    .meas_max_i (meas_max_q),
    .err_o      (err_s1),
    .diff_o     (diff_s1),
    .sum_o      (sum_s1)
  );

  pwci_mult #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_mult (
    .clk_i     (clk_i),
    .en_i      (en2),
    .gain_p_i  (gain_p_q),
    .gain_i_i  (gain_i_q),
    .gain_d_i  (gain_d_q),
    .err_i     (err_s1),
    .diff_i    (diff_s1),
    .sum_i     (sum_s1),
    .prod_p_o  (prod_p),
    .prod_d_o  (prod_d),
    .prod_il_o (prod_il),
    .prod_ih_o (prod_ih)
  );

  pwci_post #(
    .SUM_WIDTH     (SUM_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_post (
    .clk_i       (clk_i),
    .en_sum_i    (en3),
    .en_out_i    (en4),
    .prod_p_i    (prod_p),
    .prod_d_i    (prod_d),
    .prod_il_i   (prod_il),
    .prod_ih_i   (prod_ih),
    .out_limit_i (out_limit_q),
    .out_o       (out_data_o)
  );

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

endmodule
